/* rtl/core/fct_pkg.sv */
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types, constants and helpers of the FAT12 cluster table engine.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int DATA_CLUSTERS = 2847;
  localparam int TABLE_BYTES   = 4608;
  localparam int FIRST_CLUSTER = 2;

  // Each table copy is split in an even and an odd byte bank
  localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam logic [11:0] END_LIMIT_C   = 12'(DATA_CLUSTERS + FIRST_CLUSTER);
  localparam logic [11:0] FIRST_C       = 12'(FIRST_CLUSTER);
  localparam logic [11:0] DATA_MAX_C    = 12'(DATA_CLUSTERS);
  localparam logic [13:0] TABLE_BYTES_C = 14'(TABLE_BYTES);
  localparam logic [11:0] END_MARK_C    = 12'hFF8;
  localparam logic [11:0] EOC_C         = 12'hFFF;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_READ  = 3'd1,
    OP_WRITE = 3'd2,
    OP_FIND  = 3'd3,
    OP_COUNT = 3'd4,
    OP_FREE  = 3'd5,
    OP_ALLOC = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RW,
    S_SCAN_CHK,
    S_SCAN_TST,
    S_ALOOP,
    S_LINK_RD,
    S_LINK_WR,
    S_FIN_RD,
    S_FIN_WR,
    S_FREE_CHK,
    S_FREE_WR,
    S_FREE_END,
    S_DONE
  } state_e;

  // What a scan is looking for
  typedef enum logic [2:0] {
    M_FIND,
    M_COUNT,
    M_ACNT,
    M_AFIRST,
    M_ANEXT
  } mode_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_CLAMP,
    CUR_FIRST,
    CUR_INC,
    CUR_PREV_INC,
    CUR_ENTRY
  } cur_op_e;

  typedef enum logic [1:0] {
    N_HOLD,
    N_CLR,
    N_ONE,
    N_INC
  } n_op_e;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_CUR,
    RES_N,
    RES_ENTRY
  } res_op_e;

  typedef enum logic [1:0] {
    W_VAL,
    W_ZERO,
    W_CUR,
    W_END
  } wsel_e;

  typedef struct packed {
    logic    cap;
    cur_op_e cur_op;
    n_op_e   n_op;
    logic    prev_ld;
    res_op_e res_op;
    logic    st_ld;
    status_e st_val;
    logic    use_prev;
    logic    mem_we;
    wsel_e   wsel;
    logic    byte_we;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic addr_ok;
    logic cur_ok;
    logic cur_data_ok;
    logic cur_zero;
    logic len_zero;
    logic entry_zero;
    logic entry_end;
    logic n_at_max;
    logic len_gt_n;
    logic n_lt_len;
  } stat_t;

  // Byte offset of an entry: c * 3 / 2
  function automatic logic [12:0] entry_off(input logic [11:0] c);
    entry_off = {1'b0, c} + {2'b00, c[11:1]};
  endfunction

  // Entry index below the limit with both of its bytes inside the table
  function automatic logic entry_ok(input logic [11:0] c);
    entry_ok = (c < END_LIMIT_C) && (({1'b0, entry_off(c)} + 14'd1) < TABLE_BYTES_C);
  endfunction

endpackage

/* rtl/core/fct_ctrl.sv */
// ----------------------------------------------------------------------------
// fct_ctrl
// Command sequencer: steps each transaction through reads, scans and writes.
// ----------------------------------------------------------------------------
module fct_ctrl import fct_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_FIND;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Output slot
  always_comb begin
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        unique case (stat_i.op)
          OP_READ, OP_WRITE: state_d = stat_i.cur_ok ? S_RW : S_DONE;
          OP_FIND: begin
            mode_d  = M_FIND;
            state_d = S_SCAN_CHK;
          end
          OP_COUNT: begin
            mode_d  = M_COUNT;
            state_d = S_SCAN_CHK;
          end
          OP_FREE:  state_d = stat_i.cur_zero ? S_DONE : S_FREE_CHK;
          OP_ALLOC: begin
            mode_d  = M_ACNT;
            state_d = stat_i.len_zero ? S_DONE : S_SCAN_CHK;
          end
          default:  state_d = S_DONE;
        endcase
      end
      S_RW: state_d = S_DONE;
      S_SCAN_CHK: begin
        if (stat_i.cur_ok) begin
          state_d = S_SCAN_TST;
        end else begin
          unique case (mode_q)
            M_ACNT: begin
              if (stat_i.len_gt_n) begin
                state_d = S_DONE;
              end else begin
                mode_d  = M_AFIRST;
                state_d = S_SCAN_CHK;
              end
            end
            M_ANEXT: state_d = S_FIN_RD;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN_TST: begin
        state_d = S_SCAN_CHK;
        if (stat_i.entry_zero) begin
          unique case (mode_q)
            M_FIND:   state_d = S_DONE;
            M_AFIRST: state_d = S_ALOOP;
            M_ANEXT:  state_d = S_LINK_RD;
            default:  state_d = S_SCAN_CHK;
          endcase
        end
      end
      S_ALOOP: begin
        if (stat_i.n_lt_len) begin
          mode_d  = M_ANEXT;
          state_d = S_SCAN_CHK;
        end else begin
          state_d = S_FIN_RD;
        end
      end
      S_LINK_RD: state_d = S_LINK_WR;
      S_LINK_WR: state_d = S_ALOOP;
      S_FIN_RD:  state_d = S_FIN_WR;
      S_FIN_WR:  state_d = S_DONE;
      S_FREE_CHK: begin
        if (stat_i.n_at_max || !stat_i.cur_data_ok) begin
          state_d = S_DONE;
        end else begin
          state_d = S_FREE_WR;
        end
      end
      S_FREE_WR: state_d = stat_i.entry_end ? S_FREE_END : S_FREE_CHK;
      S_FREE_END: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '{cap: 1'b0, cur_op: CUR_HOLD, n_op: N_HOLD, prev_ld: 1'b0,
              res_op: RES_HOLD, st_ld: 1'b0, st_val: ST_OK, use_prev: 1'b0,
              mem_we: 1'b0, wsel: W_VAL, byte_we: 1'b0, out_ld: 1'b0};
    unique case (state_q)
      S_IDLE: cmd_o.cap = in_valid_i;
      S_START: begin
        unique case (stat_i.op)
          OP_LOAD: begin
            cmd_o.byte_we = stat_i.addr_ok;
            cmd_o.st_ld   = !stat_i.addr_ok;
            cmd_o.st_val  = ST_RANGE;
          end
          OP_READ, OP_WRITE: begin
            cmd_o.st_ld  = !stat_i.cur_ok;
            cmd_o.st_val = ST_RANGE;
          end
          OP_FIND: cmd_o.cur_op = CUR_CLAMP;
          OP_COUNT, OP_ALLOC: begin
            cmd_o.cur_op = CUR_FIRST;
            cmd_o.n_op   = N_CLR;
          end
          OP_FREE: cmd_o.n_op = N_CLR;
          default: cmd_o.n_op = N_HOLD;
        endcase
      end
      S_RW: begin
        if (stat_i.op == OP_READ) begin
          cmd_o.res_op = RES_ENTRY;
        end else begin
          cmd_o.mem_we = 1'b1;
          cmd_o.wsel   = W_VAL;
        end
      end
      S_SCAN_CHK: begin
        if (!stat_i.cur_ok) begin
          unique case (mode_q)
            M_FIND: begin
              cmd_o.st_ld  = 1'b1;
              cmd_o.st_val = ST_NO_FREE;
            end
            M_COUNT: cmd_o.res_op = RES_N;
            M_ACNT: begin
              cmd_o.st_ld  = stat_i.len_gt_n;
              cmd_o.st_val = ST_NO_SPACE;
              cmd_o.cur_op = CUR_FIRST;
            end
            default: begin
              cmd_o.st_ld  = 1'b1;
              cmd_o.st_val = ST_NO_SPACE;
            end
          endcase
        end
      end
      S_SCAN_TST: begin
        cmd_o.cur_op = CUR_INC;
        if (stat_i.entry_zero) begin
          unique case (mode_q)
            M_FIND: begin
              cmd_o.cur_op = CUR_HOLD;
              cmd_o.res_op = RES_CUR;
            end
            M_AFIRST: begin
              cmd_o.cur_op  = CUR_HOLD;
              cmd_o.res_op  = RES_CUR;
              cmd_o.prev_ld = 1'b1;
              cmd_o.n_op    = N_ONE;
            end
            M_ANEXT: cmd_o.cur_op = CUR_HOLD;
            default: cmd_o.n_op = N_INC;
          endcase
        end
      end
      S_ALOOP: begin
        if (stat_i.n_lt_len) cmd_o.cur_op = CUR_PREV_INC;
      end
      S_LINK_RD: cmd_o.use_prev = 1'b1;
      S_LINK_WR: begin
        cmd_o.use_prev = 1'b1;
        cmd_o.mem_we   = 1'b1;
        cmd_o.wsel     = W_CUR;
        cmd_o.prev_ld  = 1'b1;
        cmd_o.n_op     = N_INC;
      end
      S_FIN_RD: cmd_o.use_prev = 1'b1;
      S_FIN_WR: begin
        cmd_o.use_prev = 1'b1;
        cmd_o.mem_we   = 1'b1;
        cmd_o.wsel     = W_END;
      end
      S_FREE_CHK: begin
        if (stat_i.n_at_max || !stat_i.cur_data_ok) begin
          cmd_o.res_op = RES_N;
          cmd_o.st_ld  = 1'b1;
          cmd_o.st_val = ST_RANGE;
        end
      end
      S_FREE_WR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = W_ZERO;
        cmd_o.n_op   = N_INC;
        if (!stat_i.entry_end) cmd_o.cur_op = CUR_ENTRY;
      end
      S_FREE_END: cmd_o.res_op = RES_N;
      S_DONE: cmd_o.out_ld = !out_valid_q || !out_stall_i;
      default: cmd_o.cap = 1'b0;
    endcase
  end

endmodule

/* rtl/core/fct_datapath.sv */
// ----------------------------------------------------------------------------
// fct_datapath
// Table memories, entry pack/unpack, cluster pointers, counters, results.
// ----------------------------------------------------------------------------
module fct_datapath import fct_pkg::*; (
  input  logic        clk_i,
  input  logic [2:0]  op_i,
  input  logic        copy_select_i,
  input  logic [12:0] byte_addr_i,
  input  logic [7:0]  byte_data_i,
  input  logic [11:0] cluster_i,
  input  logic [11:0] entry_value_i,
  input  logic [11:0] chain_length_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic [11:0] result_value_o,
  output logic [1:0]  status_o
);

  // Byte banks: copy A/B, even/odd byte offsets
  logic [7:0] mem_ae [BANK_DEPTH];
  logic [7:0] mem_ao [BANK_DEPTH];
  logic [7:0] mem_be [BANK_DEPTH];
  logic [7:0] mem_bo [BANK_DEPTH];
  logic [7:0] rd_ae_q, rd_ao_q, rd_be_q, rd_bo_q;

  op_e         op_q;
  logic        sel_q;
  logic [12:0] addr_q;
  logic [7:0]  data_q;
  logic [11:0] val_q, len_q;
  logic [11:0] cur_q, cur_d, prev_q, n_q, n_d, res_q, res_d;
  status_e     st_q;
  logic [11:0] out_res_q;
  status_e     out_st_q;
  logic        rd_odd_q, rd_swap_q;

  logic [11:0] acl;
  logic [12:0] aoff, aoff_inc;
  logic [BANK_AW-1:0] idx_e, idx_o, bidx;
  logic [15:0] wa, wb, word, wnew;
  logic [11:0] entry, wval;
  logic [7:0]  wr_e, wr_o;
  logic        we_ae, we_ao, we_be, we_bo;
  logic [7:0]  d_ae, d_ao, d_be, d_bo;

  // Access address and bank indexes
  assign acl      = cmd_i.use_prev ? prev_q : cur_q;
  assign aoff     = entry_off(acl);
  assign aoff_inc = aoff + 13'd1;
  assign idx_e    = aoff_inc[BANK_AW:1];
  assign idx_o    = aoff[BANK_AW:1];
  assign bidx     = addr_q[BANK_AW:1];

  // Word unpack and copy compare
  assign wa    = rd_swap_q ? {rd_ae_q, rd_ao_q} : {rd_ao_q, rd_ae_q};
  assign wb    = rd_swap_q ? {rd_be_q, rd_bo_q} : {rd_bo_q, rd_be_q};
  assign word  = (wa == wb) ? wa : 16'hFFFF;
  assign entry = rd_odd_q ? word[15:4] : word[11:0];

  // Word merge for an entry write
  always_comb begin
    unique case (cmd_i.wsel)
      W_VAL:   wval = val_q;
      W_ZERO:  wval = 12'd0;
      W_CUR:   wval = cur_q;
      W_END:   wval = EOC_C;
      default: wval = 12'd0;
    endcase
    if (rd_odd_q) begin
      wnew = {wval, word[3:0]};
    end else begin
      wnew = {word[15:12], wval};
    end
  end

  assign wr_e = rd_swap_q ? wnew[15:8] : wnew[7:0];
  assign wr_o = rd_swap_q ? wnew[7:0]  : wnew[15:8];

  // Bank write enables and data
  assign we_ae = cmd_i.mem_we || (cmd_i.byte_we && !sel_q && !addr_q[0]);
  assign we_ao = cmd_i.mem_we || (cmd_i.byte_we && !sel_q &&  addr_q[0]);
  assign we_be = cmd_i.mem_we || (cmd_i.byte_we &&  sel_q && !addr_q[0]);
  assign we_bo = cmd_i.mem_we || (cmd_i.byte_we &&  sel_q &&  addr_q[0]);
  assign d_ae  = cmd_i.mem_we ? wr_e : data_q;
  assign d_ao  = cmd_i.mem_we ? wr_o : data_q;
  assign d_be  = cmd_i.mem_we ? wr_e : data_q;
  assign d_bo  = cmd_i.mem_we ? wr_o : data_q;

  // Memories
  always_ff @(posedge clk_i) begin
    if (we_ae) mem_ae[cmd_i.mem_we ? idx_e : bidx] <= d_ae;
    if (we_ao) mem_ao[cmd_i.mem_we ? idx_o : bidx] <= d_ao;
    if (we_be) mem_be[cmd_i.mem_we ? idx_e : bidx] <= d_be;
    if (we_bo) mem_bo[cmd_i.mem_we ? idx_o : bidx] <= d_bo;
    rd_ae_q   <= mem_ae[idx_e];
    rd_ao_q   <= mem_ao[idx_o];
    rd_be_q   <= mem_be[idx_e];
    rd_bo_q   <= mem_bo[idx_o];
    rd_odd_q  <= acl[0];
    rd_swap_q <= aoff[0];
  end

  // Pointer, counter and result updates
  always_comb begin
    unique case (cmd_i.cur_op)
      CUR_HOLD:     cur_d = cur_q;
      CUR_CLAMP:    cur_d = (cur_q < FIRST_C) ? FIRST_C : cur_q;
      CUR_FIRST:    cur_d = FIRST_C;
      CUR_INC:      cur_d = cur_q + 12'd1;
      CUR_PREV_INC: cur_d = prev_q + 12'd1;
      CUR_ENTRY:    cur_d = entry;
      default:      cur_d = cur_q;
    endcase
    unique case (cmd_i.n_op)
      N_HOLD:  n_d = n_q;
      N_CLR:   n_d = 12'd0;
      N_ONE:   n_d = 12'd1;
      N_INC:   n_d = n_q + 12'd1;
      default: n_d = n_q;
    endcase
    unique case (cmd_i.res_op)
      RES_HOLD:  res_d = res_q;
      RES_CUR:   res_d = cur_q;
      RES_N:     res_d = n_q;
      RES_ENTRY: res_d = entry;
      default:   res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q   <= op_e'(op_i);
      sel_q  <= copy_select_i;
      addr_q <= byte_addr_i;
      data_q <= byte_data_i;
      val_q  <= entry_value_i;
      len_q  <= chain_length_i;
      cur_q  <= cluster_i;
      res_q  <= 12'd0;
      st_q   <= ST_OK;
    end else begin
      cur_q <= cur_d;
      res_q <= res_d;
      if (cmd_i.st_ld) st_q <= cmd_i.st_val;
    end
    n_q <= n_d;
    if (cmd_i.prev_ld) prev_q <= cur_q;
    if (cmd_i.out_ld) begin
      out_res_q <= res_q;
      out_st_q  <= st_q;
    end
  end

  // Status to the sequencer
  assign stat_o.op          = op_q;
  assign stat_o.addr_ok     = ({1'b0, addr_q} < TABLE_BYTES_C);
  assign stat_o.cur_ok      = entry_ok(cur_q);
  assign stat_o.cur_data_ok = (cur_q >= FIRST_C) && entry_ok(cur_q);
  assign stat_o.cur_zero    = (cur_q == 12'd0);
  assign stat_o.len_zero    = (len_q == 12'd0);
  assign stat_o.entry_zero  = (entry == 12'd0);
  assign stat_o.entry_end   = (entry >= END_MARK_C);
  assign stat_o.n_at_max    = (n_q == DATA_MAX_C);
  assign stat_o.len_gt_n    = (len_q > n_q);
  assign stat_o.n_lt_len    = (n_q < len_q);

  assign result_value_o = out_res_q;
  assign status_o       = out_st_q;

endmodule

/* rtl/core/fat12_cluster_table_engine_unit.sv */
// ----------------------------------------------------------------------------
// fat12_cluster_table_engine_unit
// FAT12 table engine with two mirrored byte copies and chain commands.
// ----------------------------------------------------------------------------
// One command per transaction, one result per command, taken one at a time.
// Byte load writes its byte; entry read or write fetches the word, then reads
// or merges the entry; each then waits for the output slot. Scans (find free,
// count free) check, then test each entry visited, up to the full table. Free
// chain checks, then clears each cluster. Allocate runs one count scan, then
// a forward scan with a link read and write for each cluster allocated. One
// table access per cycle with registered read data; each copy is held in an
// even and an odd byte bank so a 16-bit word is fetched in a single access.
// Table contents are undefined until loaded; there is no clearing pass.
module fat12_cluster_table_engine_unit import fct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic        copy_select_i,
  input  logic [12:0] byte_addr_i,
  input  logic [7:0]  byte_data_i,
  input  logic [11:0] cluster_i,
  input  logic [11:0] entry_value_i,
  input  logic [11:0] chain_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] result_value_o,
  output logic [1:0]  status_o
);

  cmd_t  cmd;
  stat_t stat;

  fct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fct_datapath u_datapath (
    .clk_i          (clk_i),
    .op_i           (op_i),
    .copy_select_i  (copy_select_i),
    .byte_addr_i    (byte_addr_i),
    .byte_data_i    (byte_data_i),
    .cluster_i      (cluster_i),
    .entry_value_i  (entry_value_i),
    .chain_length_i (chain_length_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

endmodule

/* sim/fat12_cluster_table_engine_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fat12_cluster_table_engine_unit_tb
// Self-checking bench for the FAT12 cluster table engine. A behavioral copy
// of both table copies predicts every command result; results are compared
// in order while both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module fat12_cluster_table_engine_unit_tb import fct_pkg::*; ();

  localparam logic [2:0] OP_UNUSED  = 3'd7;
  localparam int         IDLE_LIMIT = 100000;
  localparam int         RAND_ITEMS = 1350;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  op_i = '0;
  logic        copy_select_i = 1'b0;
  logic [12:0] byte_addr_i = '0;
  logic [7:0]  byte_data_i = '0;
  logic [11:0] cluster_i = '0;
  logic [11:0] entry_value_i = '0;
  logic [11:0] chain_length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [11:0] result_value_o;
  logic [1:0]  status_o;

  fat12_cluster_table_engine_unit u_dut (.*);

  // Shadow table copies and expected result store
  logic [7:0]  shadow_a[TABLE_BYTES];
  logic [7:0]  shadow_b[TABLE_BYTES];
  logic [11:0] exp_value_q[$];
  status_e     exp_status_q[$];
  logic [11:0] chain_heads_q[$];
  int          fail_cnt = 0;
  int          quiet_cycles = 0;
  bit          no_idle = 1'b0;
  int          stall_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- table predictor ----------------
  function automatic bit entry_valid(int c);
    return c < DATA_CLUSTERS + FIRST_CLUSTER && (c * 3 / 2) + 1 < TABLE_BYTES;
  endfunction

  function automatic logic [15:0] table_word(int c);
    int off;
    logic [15:0] wa, wb;
    off = c * 3 / 2;
    wa = {shadow_a[off+1], shadow_a[off]};
    wb = {shadow_b[off+1], shadow_b[off]};
    return (wa == wb) ? wa : 16'hFFFF;
  endfunction

  function automatic logic [11:0] entry_read(int c);
    logic [15:0] w;
    w = table_word(c);
    return c[0] ? w[15:4] : w[11:0];
  endfunction

  function automatic void entry_write(int c, logic [11:0] v);
    int off;
    logic [15:0] w;
    off = c * 3 / 2;
    w = table_word(c);
    if (c[0]) w = {v, w[3:0]};
    else w = {w[15:12], v};
    shadow_a[off] = w[7:0];
    shadow_a[off+1] = w[15:8];
    shadow_b[off] = w[7:0];
    shadow_b[off+1] = w[15:8];
  endfunction

  function automatic int first_free_from(int origin);
    int c;
    c = (origin < FIRST_CLUSTER) ? FIRST_CLUSTER : origin;
    for (; entry_valid(c); c++) if (entry_read(c) == 12'd0) return c;
    return -1;
  endfunction

  function automatic int free_total();
    int n;
    n = 0;
    for (int c = FIRST_CLUSTER; entry_valid(c); c++) if (entry_read(c) == 12'd0) n++;
    return n;
  endfunction

  // Applies one command to the shadow tables and queues its result
  function automatic void predict_command(logic [2:0] op, logic sel, logic [12:0] addr,
                                          logic [7:0] data, logic [11:0] cl,
                                          logic [11:0] val, logic [11:0] len);
    logic [11:0] res;
    status_e st;
    int cur, n, steps, f, prev;
    logic [11:0] nxt;
    res = '0;
    st = ST_OK;
    case (op)
      OP_LOAD: begin
        if (addr < TABLE_BYTES) begin
          if (sel) shadow_b[addr] = data;
          else shadow_a[addr] = data;
        end else st = ST_RANGE;
      end
      OP_READ: begin
        if (entry_valid(cl)) res = entry_read(cl);
        else st = ST_RANGE;
      end
      OP_WRITE: begin
        if (entry_valid(cl)) entry_write(cl, val);
        else st = ST_RANGE;
      end
      OP_FIND: begin
        f = first_free_from(cl);
        if (f < 0) st = ST_NO_FREE;
        else res = 12'(f);
      end
      OP_COUNT: res = 12'(free_total());
      OP_FREE: begin
        cur = cl;
        n = 0;
        if (cur != 0) begin
          for (steps = 0; steps < DATA_CLUSTERS; steps++) begin
            if (!(cur >= FIRST_CLUSTER && entry_valid(cur))) begin
              st = ST_RANGE;
              break;
            end
            nxt = entry_read(cur);
            entry_write(cur, 12'd0);
            n++;
            if (nxt >= END_MARK_C) break;
            cur = nxt;
          end
          if (steps >= DATA_CLUSTERS) st = ST_RANGE;
          res = 12'(n);
        end
      end
      OP_ALLOC: begin
        if (len != 0) begin
          if (len > free_total()) st = ST_NO_SPACE;
          else begin
            f = first_free_from(FIRST_CLUSTER);
            if (f < 0) st = ST_NO_SPACE;
            else begin
              res = 12'(f);
              prev = f;
              for (int i = 1; i < len; i++) begin
                f = first_free_from(prev + 1);
                if (f < 0) begin
                  st = ST_NO_SPACE;
                  break;
                end
                entry_write(prev, 12'(f));
                prev = f;
              end
              entry_write(prev, EOC_C);
            end
          end
        end
      end
      default: ;
    endcase
    exp_value_q.push_back(res);
    exp_status_q.push_back(st);
  endfunction

  // ---------------- command driver ----------------
  task automatic send_command(logic [2:0] op, logic sel = 0, logic [12:0] addr = 0,
                              logic [7:0] data = 0, logic [11:0] cl = 0,
                              logic [11:0] val = 0, logic [11:0] len = 0);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    copy_select_i <= sel;
    byte_addr_i <= addr;
    byte_data_i <= data;
    cluster_i <= cl;
    entry_value_i <= val;
    chain_length_i <= len;
    do @(posedge clk_i); while (in_stall_o);
    predict_command(op, sel, addr, data, cl, val, len);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (exp_value_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------- result checker and receiver stalls ----------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (exp_value_q.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d", $time,
                   result_value_o, status_o);
          fail_cnt++;
        end else begin
          if (result_value_o !== exp_value_q[0]) begin
            $display("%0t: result_value expected %h actual %h", $time,
                     exp_value_q[0], result_value_o);
            fail_cnt++;
          end
          if (status_o !== exp_status_q[0]) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_status_q[0], status_o);
            fail_cnt++;
          end
          void'(exp_value_q.pop_front());
          void'(exp_status_q.pop_front());
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 11);
      end
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------- tests ----------------
  // Writes every byte of both copies; entries 0 and 1 hold the media marks
  task automatic test_fill_tables();
    logic [7:0] b;
    no_idle = 1'b1;
    for (int i = 0; i < TABLE_BYTES; i++) begin
      b = (i == 0) ? 8'hF0 : (i < 3) ? 8'hFF : 8'h00;
      send_command(OP_LOAD, 1'b0, 13'(i), b);
      send_command(OP_LOAD, 1'b1, 13'(i), b);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_byte_load();
    send_command(OP_LOAD, 1'b1, 13'd30, 8'h12);       // copies now differ
    send_command(OP_READ, 0, 0, 0, 12'd20);            // mismatched word
    send_command(OP_WRITE, 0, 0, 0, 12'd20, 12'h123);  // keeps 0xF nibble
    send_command(OP_READ, 0, 0, 0, 12'd21);
    send_command(OP_LOAD, 1'b0, 13'd4607, 8'hFF);
    send_command(OP_LOAD, 1'b1, 13'd8191, 8'hAA);     // address out of range
  endtask

  task automatic test_entry_rw();
    send_command(OP_WRITE, 0, 0, 0, 12'd2848, 12'hFFF);
    send_command(OP_READ, 0, 0, 0, 12'd2848);
    send_command(OP_READ, 0, 0, 0, 12'd2849);
    send_command(OP_WRITE, 0, 0, 0, 12'd4095, 12'h555);
    send_command(OP_READ, 0, 0, 0, 12'd0);
    send_command(OP_UNUSED, 1'b1, 13'h1FFF, 8'hFF, 12'hFFF, 12'hFFF, 12'hFFF);
  endtask

  task automatic test_scans();
    send_command(OP_FIND, 0, 0, 0, 12'd0);
    send_command(OP_FIND, 0, 0, 0, 12'd4095);          // nothing found
    send_command(OP_COUNT);
  endtask

  task automatic test_chains();
    send_command(OP_ALLOC, 0, 0, 0, 0, 0, 12'd0);
    send_command(OP_ALLOC, 0, 0, 0, 0, 0, 12'd4095);   // too few free
    send_command(OP_ALLOC, 0, 0, 0, 0, 0, 12'd3);
    send_command(OP_READ, 0, 0, 0, 12'd3);
    send_command(OP_FREE, 0, 0, 0, 12'd0);             // empty chain
    send_command(OP_FREE, 0, 0, 0, 12'd2);
    send_command(OP_WRITE, 0, 0, 0, 12'd10, 12'hFF0);  // reserved link
    send_command(OP_FREE, 0, 0, 0, 12'd10);
    // Exhaust the table, then release it again
    wait_drained();
    send_command(OP_ALLOC, 0, 0, 0, 0, 0, 12'(free_total()));
    send_command(OP_FIND, 0, 0, 0, 12'd1);
    send_command(OP_FREE, 0, 0, 0, 12'd2);
  endtask

  task automatic test_random();
    int pick, item_cnt;
    logic [11:0] head, v;
    item_cnt = 0;
    while (item_cnt < RAND_ITEMS) begin
      no_idle = ((item_cnt / 150) % 4) == 2;
      if (item_cnt == RAND_ITEMS / 2) wait_drained();
      pick = $urandom_range(0, 99);
      v = ($urandom_range(0, 1)) ? 12'd0 :
          ($urandom_range(0, 1)) ? 12'($urandom_range(12'hFF8, 12'hFFF)) : 12'($urandom);
      if (pick < 22)
        send_command(OP_LOAD, 1'($urandom),
                     ($urandom_range(0, 9) == 0) ? 13'($urandom_range(TABLE_BYTES, 8191))
                                                 : 13'($urandom_range(0, TABLE_BYTES - 1)),
                     ($urandom_range(0, 1)) ? 8'h00 : 8'($urandom));
      else if (pick < 42)
        send_command(OP_READ, 0, 0, 0, ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                       : 12'($urandom_range(0, 2848)));
      else if (pick < 62)
        send_command(OP_WRITE, 0, 0, 0, ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                        : 12'($urandom_range(0, 2848)), v);
      else if (pick < 72)
        send_command(OP_FIND, 0, 0, 0, 12'($urandom));
      else if (pick < 73)
        send_command(OP_COUNT);
      else if (pick < 77) begin
        // well-formed: allocate, follow the head link, later free it
        head = 12'(first_free_from(FIRST_CLUSTER));
        send_command(OP_ALLOC, 0, 0, 0, 0, 0,
                     ($urandom_range(0, 19) == 0) ? 12'($urandom_range(0, 2847))
                                                  : 12'($urandom_range(0, 8)));
        wait_drained();
        chain_heads_q.push_back(head);
        send_command(OP_READ, 0, 0, 0, head);
        item_cnt++;
      end else if (pick < 88) begin
        if (chain_heads_q.size() != 0 && $urandom_range(0, 3) != 0)
          head = chain_heads_q.pop_front();
        else head = 12'($urandom_range(0, 2848));
        send_command(OP_FREE, 0, 0, 0, head);
      end else if (pick < 90)
        send_command(OP_UNUSED, 1'($urandom), 13'($urandom), 8'($urandom),
                     12'($urandom), 12'($urandom), 12'($urandom));
      else
        send_command(OP_READ, 0, 0, 0, 12'($urandom_range(0, 60)));
      item_cnt++;
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_tables();
    test_byte_load();
    test_entry_rw();
    test_scans();
    test_chains();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/fct_pkg.sv
rtl/core/fct_ctrl.sv
rtl/core/fct_datapath.sv
rtl/core/fat12_cluster_table_engine_unit.sv
sim/fat12_cluster_table_engine_unit_tb.sv
